// ===== hdl/kcd_pkg.sv =====
package kcd_pkg;

	// Port field widths
	localparam int CMD_W   = 2;
	localparam int NODE_W  = 10;
	localparam int CORE_W  = 10;
	localparam int COUNT_W = 11;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 24;

	// Command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_ADJ   = 2'd0,
		CMD_MARK  = 2'd1,
		CMD_RUN   = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	// Result kinds
	localparam logic KIND_RUN   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE,
		ST_LD_RD, ST_LD_WR, ST_MK_RD, ST_MK_WR, ST_QY_RD, ST_QY_DAT,
		ST_ZERO, ST_CNT_RD, ST_CNT_LS, ST_CNT_WR, ST_PFX_RD, ST_PFX_WR,
		ST_PLC_RD, ST_PLC_LS, ST_PLC_WR, ST_SHF_RD, ST_SHF_WR, ST_SHF_ZERO,
		ST_PL_SO, ST_PL_V, ST_PL_HEAD, ST_PL_ADJ, ST_PL_U, ST_PL_CHK, ST_PL_W,
		ST_PL_SW1, ST_PL_SW2, ST_RUN_OUT, ST_OUT
	} state_t;

endpackage

// ===== hdl/kcd_ram.sv =====
module kcd_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/kcore_decomposition.sv =====
// Channel   Dir  Beat content (tdata low bit up)                     Sideband
// s_axis    in   cmd[1:0] node_id[11:2] neighbor_id[21:12] pad       -
// m_axis    out  result_node[9:0] core_number[19:10] has_core[20]    tuser: result_kind
//                overflow[21] pad
// cfg       in   node_count on cfg_wr_data when cfg_wr_en             -
//
// Adjacency entry and mark each take an accept, then a read-modify-write of node memory.
// A query reads the core memory, then fills the output register. A run zeroes the level counts,
// counts unmarked nodes per degree, forms prefix sums, places nodes, shifts the starts, then peels
// nodes and their adjacency entries, paced by the single ports of the state memories.
// After reset the node memory is cleared entry by entry; s_axis_tready stays low then.
// A result waiting on m_axis does not stop intake; only the next result waits for it.
module kcore_decomposition #(
	parameter int MAX_NODES       = 1024,
	parameter int MAX_ADJ_ENTRIES = 8192
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [kcd_pkg::IN_W-1:0]   s_axis_tdata,  // cmd, node_id, neighbor_id
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [kcd_pkg::OUT_W-1:0]  m_axis_tdata,  // result_node, core_number, has_core, overflow
	output logic                       m_axis_tuser,  // result_kind
	input  logic                       cfg_wr_en,
	input  logic [kcd_pkg::COUNT_W-1:0] cfg_wr_data
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int NCW = NW + 1;
	localparam int AW  = $clog2(MAX_ADJ_ENTRIES);
	localparam int FW  = AW + 1;
	localparam int IW  = (FW > NCW) ? FW + 1 : NCW + 1;

	kcd_pkg::state_t st_q, st_d;

	// Input fields
	logic [kcd_pkg::CMD_W-1:0]  in_cmd;
	logic [kcd_pkg::NODE_W-1:0] in_node, in_nb;
	assign in_cmd  = s_axis_tdata[1:0];
	assign in_node = s_axis_tdata[11:2];
	assign in_nb   = s_axis_tdata[21:12];

	// Control and datapath registers
	logic [kcd_pkg::COUNT_W-1:0] ncount_q;
	logic [FW-1:0]  fill_q;
	logic [NW-1:0]  largest_q, top_q, best_q;
	logic           ovf_q, ran_q, any_q;
	logic [NCW-1:0] n_run_q, idx_q, start_q, total_q;
	logic [kcd_pkg::NODE_W-1:0] node_q, nb_q;
	logic [NW-1:0]  v_q, dv_q, deg_q, j_q, u_q, du_q, pu_q, pw_q;
	logic [AW-1:0]  row_q;
	logic           res_kind_q, res_has_q;
	logic [kcd_pkg::NODE_W-1:0] res_node_q;
	logic [kcd_pkg::CORE_W-1:0] res_core_q;
	logic           mvalid_q, mkind_q;
	logic [kcd_pkg::OUT_W-1:0] mdata_q;

	// Memory ports
	logic          nd_we, rs_we, ad_we, lv_we, so_we, po_we, ls_we, co_we;
	logic [NW-1:0] nd_wa, nd_ra, rs_wa, rs_ra, lv_wa, lv_ra, so_wa, so_ra;
	logic [NW-1:0] po_wa, po_ra, ls_wa, ls_ra, co_wa, co_ra;
	logic [AW-1:0] ad_wa, ad_ra;
	logic [NW:0]   nd_wd, nd_rd, lv_wd, lv_rd, co_wd, co_rd;
	logic [AW-1:0] rs_wd, rs_rd;
	logic [NW-1:0] ad_wd, ad_rd, so_wd, so_rd, po_wd, po_rd;
	logic [NCW-1:0] ls_wd, ls_rd;

	kcd_ram #(.WIDTH(NW+1), .DEPTH(MAX_NODES)) u_node (.clk(clk), .we(nd_we), .waddr(nd_wa),
		.wdata(nd_wd), .raddr(nd_ra), .rdata(nd_rd));
	kcd_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_row (.clk(clk), .we(rs_we), .waddr(rs_wa),
		.wdata(rs_wd), .raddr(rs_ra), .rdata(rs_rd));
	kcd_ram #(.WIDTH(NW), .DEPTH(MAX_ADJ_ENTRIES)) u_adj (.clk(clk), .we(ad_we),
		.waddr(ad_wa), .wdata(ad_wd), .raddr(ad_ra), .rdata(ad_rd));
	kcd_ram #(.WIDTH(NW+1), .DEPTH(MAX_NODES)) u_live (.clk(clk), .we(lv_we), .waddr(lv_wa),
		.wdata(lv_wd), .raddr(lv_ra), .rdata(lv_rd));
	kcd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_order (.clk(clk), .we(so_we), .waddr(so_wa),
		.wdata(so_wd), .raddr(so_ra), .rdata(so_rd));
	kcd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_pos (.clk(clk), .we(po_we), .waddr(po_wa),
		.wdata(po_wd), .raddr(po_ra), .rdata(po_rd));
	kcd_ram #(.WIDTH(NCW), .DEPTH(MAX_NODES)) u_level (.clk(clk), .we(ls_we), .waddr(ls_wa),
		.wdata(ls_wd), .raddr(ls_ra), .rdata(ls_rd));
	kcd_ram #(.WIDTH(NW+1), .DEPTH(MAX_NODES)) u_core (.clk(clk), .we(co_we), .waddr(co_wa),
		.wdata(co_wd), .raddr(co_ra), .rdata(co_rd));

	// Derived values
	logic           in_acc, node_ok, nb_ok, ld_full, u_in_run, out_free;
	logic [NCW-1:0] n_eff;
	logic [IW-1:0]  adj_idx;
	logic [NW-1:0]  idx_a, idx_m1;

	assign s_axis_tready = (st_q == kcd_pkg::ST_IDLE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign node_ok  = 32'(in_node) < MAX_NODES;
	assign nb_ok    = 32'(in_nb) < MAX_NODES;
	assign n_eff    = (32'(ncount_q) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(ncount_q);
	assign ld_full  = (32'(fill_q) >= MAX_ADJ_ENTRIES) ||
		(32'(nd_rd[NW-1:0]) >= MAX_NODES - 1);
	assign adj_idx  = IW'(row_q) + IW'(j_q);
	assign u_in_run = NCW'(ad_rd) < n_run_q;
	assign idx_a    = NW'(idx_q);
	assign idx_m1   = NW'(idx_q - NCW'(1));
	assign out_free = !mvalid_q || m_axis_tready;

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			kcd_pkg::ST_CLEAR: begin
				if (32'(idx_q) == MAX_NODES - 1) st_d = kcd_pkg::ST_IDLE;
			end
			kcd_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (in_cmd)
						kcd_pkg::CMD_ADJ:   if (node_ok && nb_ok) st_d = kcd_pkg::ST_LD_RD;
						kcd_pkg::CMD_MARK:  if (node_ok) st_d = kcd_pkg::ST_MK_RD;
						kcd_pkg::CMD_RUN:   st_d = kcd_pkg::ST_ZERO;
						kcd_pkg::CMD_QUERY: st_d = node_ok ? kcd_pkg::ST_QY_RD : kcd_pkg::ST_OUT;
						default:            st_d = kcd_pkg::ST_IDLE;
					endcase
				end
			end
			kcd_pkg::ST_LD_RD:  st_d = kcd_pkg::ST_LD_WR;
			kcd_pkg::ST_LD_WR:  st_d = kcd_pkg::ST_IDLE;
			kcd_pkg::ST_MK_RD:  st_d = kcd_pkg::ST_MK_WR;
			kcd_pkg::ST_MK_WR:  st_d = kcd_pkg::ST_IDLE;
			kcd_pkg::ST_QY_RD:  st_d = kcd_pkg::ST_QY_DAT;
			kcd_pkg::ST_QY_DAT: st_d = kcd_pkg::ST_OUT;
			kcd_pkg::ST_ZERO:   if (idx_a == top_q) st_d = kcd_pkg::ST_CNT_RD;
			kcd_pkg::ST_CNT_RD: st_d = (idx_q >= n_run_q) ? kcd_pkg::ST_PFX_RD : kcd_pkg::ST_CNT_LS;
			kcd_pkg::ST_CNT_LS: st_d = nd_rd[NW] ? kcd_pkg::ST_CNT_RD : kcd_pkg::ST_CNT_WR;
			kcd_pkg::ST_CNT_WR: st_d = kcd_pkg::ST_CNT_RD;
			kcd_pkg::ST_PFX_RD: st_d = kcd_pkg::ST_PFX_WR;
			kcd_pkg::ST_PFX_WR: st_d = (idx_a == top_q) ? kcd_pkg::ST_PLC_RD : kcd_pkg::ST_PFX_RD;
			kcd_pkg::ST_PLC_RD: begin
				if (idx_q < n_run_q) st_d = kcd_pkg::ST_PLC_LS;
				else st_d = (top_q == '0) ? kcd_pkg::ST_SHF_ZERO : kcd_pkg::ST_SHF_RD;
			end
			kcd_pkg::ST_PLC_LS: st_d = nd_rd[NW] ? kcd_pkg::ST_PLC_RD : kcd_pkg::ST_PLC_WR;
			kcd_pkg::ST_PLC_WR: st_d = kcd_pkg::ST_PLC_RD;
			kcd_pkg::ST_SHF_RD: st_d = kcd_pkg::ST_SHF_WR;
			kcd_pkg::ST_SHF_WR: st_d = (idx_q == NCW'(1)) ? kcd_pkg::ST_SHF_ZERO : kcd_pkg::ST_SHF_RD;
			kcd_pkg::ST_SHF_ZERO: st_d = kcd_pkg::ST_PL_SO;
			kcd_pkg::ST_PL_SO:  st_d = (idx_q >= total_q) ? kcd_pkg::ST_RUN_OUT : kcd_pkg::ST_PL_V;
			kcd_pkg::ST_PL_V:   st_d = kcd_pkg::ST_PL_HEAD;
			kcd_pkg::ST_PL_HEAD: st_d = kcd_pkg::ST_PL_ADJ;
			kcd_pkg::ST_PL_ADJ: begin
				if (j_q >= deg_q || adj_idx >= IW'(fill_q)) st_d = kcd_pkg::ST_PL_SO;
				else st_d = kcd_pkg::ST_PL_U;
			end
			kcd_pkg::ST_PL_U:   st_d = u_in_run ? kcd_pkg::ST_PL_CHK : kcd_pkg::ST_PL_ADJ;
			kcd_pkg::ST_PL_CHK: begin
				if (lv_rd[NW] || lv_rd[NW-1:0] <= dv_q) st_d = kcd_pkg::ST_PL_ADJ;
				else st_d = kcd_pkg::ST_PL_W;
			end
			kcd_pkg::ST_PL_W:   st_d = kcd_pkg::ST_PL_SW1;
			kcd_pkg::ST_PL_SW1: st_d = kcd_pkg::ST_PL_SW2;
			kcd_pkg::ST_PL_SW2: st_d = kcd_pkg::ST_PL_ADJ;
			kcd_pkg::ST_RUN_OUT: st_d = kcd_pkg::ST_OUT;
			kcd_pkg::ST_OUT:    if (out_free) st_d = kcd_pkg::ST_IDLE;
			default:            st_d = kcd_pkg::ST_IDLE;
		endcase
	end

	// Memory controls
	always_comb begin
		nd_we = 1'b0; nd_wa = '0; nd_wd = '0; nd_ra = '0;
		rs_we = 1'b0; rs_wa = '0; rs_wd = '0; rs_ra = '0;
		ad_we = 1'b0; ad_wa = '0; ad_wd = '0; ad_ra = '0;
		lv_we = 1'b0; lv_wa = '0; lv_wd = '0; lv_ra = '0;
		so_we = 1'b0; so_wa = '0; so_wd = '0; so_ra = '0;
		po_we = 1'b0; po_wa = '0; po_wd = '0; po_ra = '0;
		ls_we = 1'b0; ls_wa = '0; ls_wd = '0; ls_ra = '0;
		co_we = 1'b0; co_wa = '0; co_wd = '0; co_ra = '0;
		case (st_q)
			kcd_pkg::ST_CLEAR: begin
				nd_we = 1'b1; nd_wa = idx_a;
			end
			kcd_pkg::ST_LD_RD, kcd_pkg::ST_MK_RD: nd_ra = NW'(node_q);
			kcd_pkg::ST_LD_WR: begin
				if (!ld_full) begin
					nd_we = 1'b1; nd_wa = NW'(node_q);
					nd_wd = {nd_rd[NW], nd_rd[NW-1:0] + NW'(1)};
					rs_we = (nd_rd[NW-1:0] == '0); rs_wa = NW'(node_q); rs_wd = AW'(fill_q);
					ad_we = 1'b1; ad_wa = AW'(fill_q); ad_wd = NW'(nb_q);
				end
			end
			kcd_pkg::ST_MK_WR: begin
				nd_we = 1'b1; nd_wa = NW'(node_q); nd_wd = {1'b1, nd_rd[NW-1:0]};
			end
			kcd_pkg::ST_QY_RD: co_ra = NW'(node_q);
			kcd_pkg::ST_ZERO: begin
				ls_we = 1'b1; ls_wa = idx_a;
			end
			kcd_pkg::ST_CNT_RD, kcd_pkg::ST_PLC_RD: nd_ra = idx_a;
			kcd_pkg::ST_CNT_LS: begin
				lv_we = 1'b1; lv_wa = idx_a; lv_wd = nd_rd;
				co_we = 1'b1; co_wa = idx_a;
				ls_ra = nd_rd[NW-1:0];
			end
			kcd_pkg::ST_CNT_WR: begin
				ls_we = 1'b1; ls_wa = deg_q; ls_wd = ls_rd + NCW'(1);
			end
			kcd_pkg::ST_PFX_RD: ls_ra = idx_a;
			kcd_pkg::ST_PFX_WR: begin
				ls_we = 1'b1; ls_wa = idx_a; ls_wd = start_q;
			end
			kcd_pkg::ST_PLC_LS: ls_ra = nd_rd[NW-1:0];
			kcd_pkg::ST_PLC_WR: begin
				po_we = 1'b1; po_wa = idx_a; po_wd = NW'(ls_rd);
				so_we = 1'b1; so_wa = NW'(ls_rd); so_wd = idx_a;
				ls_we = 1'b1; ls_wa = deg_q; ls_wd = ls_rd + NCW'(1);
			end
			kcd_pkg::ST_SHF_RD: ls_ra = idx_m1;
			kcd_pkg::ST_SHF_WR: begin
				ls_we = 1'b1; ls_wa = idx_a; ls_wd = ls_rd;
			end
			kcd_pkg::ST_SHF_ZERO: ls_we = 1'b1;
			kcd_pkg::ST_PL_SO: so_ra = idx_a;
			kcd_pkg::ST_PL_V: begin
				lv_ra = so_rd; nd_ra = so_rd; rs_ra = so_rd;
			end
			kcd_pkg::ST_PL_HEAD: begin
				co_we = 1'b1; co_wa = v_q; co_wd = {1'b1, lv_rd[NW-1:0]};
				lv_we = 1'b1; lv_wa = v_q; lv_wd = {1'b1, lv_rd[NW-1:0]};
			end
			kcd_pkg::ST_PL_ADJ: ad_ra = AW'(adj_idx);
			kcd_pkg::ST_PL_U:   lv_ra = ad_rd;
			kcd_pkg::ST_PL_CHK: begin
				po_ra = u_q; ls_ra = lv_rd[NW-1:0];
			end
			kcd_pkg::ST_PL_W:   so_ra = NW'(ls_rd);
			kcd_pkg::ST_PL_SW1: begin
				so_we = 1'b1; so_wa = pu_q; so_wd = so_rd;
				po_we = 1'b1; po_wa = so_rd; po_wd = pu_q;
			end
			kcd_pkg::ST_PL_SW2: begin
				so_we = 1'b1; so_wa = pw_q; so_wd = u_q;
				po_we = 1'b1; po_wa = u_q; po_wd = pw_q;
				ls_we = 1'b1; ls_wa = du_q; ls_wd = NCW'(pw_q) + NCW'(1);
				lv_we = 1'b1; lv_wa = u_q; lv_wd = {1'b0, du_q - NW'(1)};
			end
			default: ;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= kcd_pkg::ST_CLEAR;
			ncount_q  <= kcd_pkg::COUNT_W'(1024);
			fill_q    <= '0;
			largest_q <= '0;
			ovf_q     <= 1'b0;
			ran_q     <= 1'b0;
			idx_q     <= '0;
			mvalid_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_wr_en) ncount_q <= cfg_wr_data;
			// output beat: load on a free slot, drop once taken
			if (st_q == kcd_pkg::ST_OUT && out_free) begin
				mvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				mvalid_q <= 1'b0;
			end
			case (st_q)
				kcd_pkg::ST_CLEAR: idx_q <= idx_q + NCW'(1);
				kcd_pkg::ST_IDLE: begin
					if (in_acc && in_cmd == kcd_pkg::CMD_RUN) begin
						ran_q <= 1'b1;
						idx_q <= '0;
					end
				end
				kcd_pkg::ST_LD_WR: begin
					if (ld_full) begin
						ovf_q <= 1'b1;
					end else begin
						fill_q <= fill_q + FW'(1);
						if (nd_rd[NW-1:0] + NW'(1) > largest_q) largest_q <= nd_rd[NW-1:0] + NW'(1);
					end
				end
				kcd_pkg::ST_ZERO: idx_q <= (idx_a == top_q) ? '0 : idx_q + NCW'(1);
				kcd_pkg::ST_CNT_RD: if (idx_q >= n_run_q) idx_q <= '0;
				kcd_pkg::ST_CNT_LS: if (nd_rd[NW]) idx_q <= idx_q + NCW'(1);
				kcd_pkg::ST_CNT_WR: idx_q <= idx_q + NCW'(1);
				kcd_pkg::ST_PFX_WR: idx_q <= (idx_a == top_q) ? '0 : idx_q + NCW'(1);
				kcd_pkg::ST_PLC_RD: if (idx_q >= n_run_q) idx_q <= NCW'(top_q);
				kcd_pkg::ST_PLC_LS: if (nd_rd[NW]) idx_q <= idx_q + NCW'(1);
				kcd_pkg::ST_PLC_WR: idx_q <= idx_q + NCW'(1);
				kcd_pkg::ST_SHF_WR: idx_q <= idx_q - NCW'(1);
				kcd_pkg::ST_SHF_ZERO: idx_q <= '0;
				kcd_pkg::ST_PL_ADJ: begin
					if (j_q >= deg_q || adj_idx >= IW'(fill_q)) idx_q <= idx_q + NCW'(1);
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			kcd_pkg::ST_IDLE: begin
				node_q     <= in_node;
				nb_q       <= in_nb;
				// node count of the last run, also used to screen queries
				if (in_acc && in_cmd == kcd_pkg::CMD_RUN) n_run_q <= n_eff;
				top_q      <= largest_q;
				best_q     <= '0;
				any_q      <= 1'b0;
				start_q    <= '0;
				res_kind_q <= kcd_pkg::KIND_QUERY;
				res_node_q <= in_node;
				res_core_q <= '0;
				res_has_q  <= 1'b0;
			end
			kcd_pkg::ST_QY_DAT: begin
				if (ran_q && co_rd[NW] && NCW'(node_q) < n_run_q) begin
					res_has_q  <= 1'b1;
					res_core_q <= kcd_pkg::CORE_W'(co_rd[NW-1:0]);
				end
			end
			kcd_pkg::ST_CNT_LS, kcd_pkg::ST_PLC_LS: deg_q <= nd_rd[NW-1:0];
			kcd_pkg::ST_PFX_WR: begin
				start_q <= start_q + ls_rd;
				total_q <= start_q + ls_rd;
			end
			kcd_pkg::ST_PL_V: v_q <= so_rd;
			kcd_pkg::ST_PL_HEAD: begin
				dv_q  <= lv_rd[NW-1:0];
				deg_q <= nd_rd[NW-1:0];
				row_q <= rs_rd;
				j_q   <= '0;
				any_q <= 1'b1;
				if (lv_rd[NW-1:0] > best_q) best_q <= lv_rd[NW-1:0];
			end
			kcd_pkg::ST_PL_ADJ: j_q <= j_q + NW'(1);
			kcd_pkg::ST_PL_U:   u_q <= ad_rd;
			kcd_pkg::ST_PL_CHK: du_q <= lv_rd[NW-1:0];
			kcd_pkg::ST_PL_W: begin
				pu_q <= po_rd;
				pw_q <= NW'(ls_rd);
			end
			kcd_pkg::ST_RUN_OUT: begin
				res_kind_q <= kcd_pkg::KIND_RUN;
				res_node_q <= '0;
				res_core_q <= kcd_pkg::CORE_W'(best_q);
				res_has_q  <= any_q;
			end
			kcd_pkg::ST_OUT: begin
				if (out_free) begin
					mkind_q <= res_kind_q;
					mdata_q <= {2'b00, ovf_q, res_has_q, res_core_q, res_node_q};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = mdata_q;
	assign m_axis_tuser  = mkind_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= MAX_ADJ_ENTRIES)
		else $error("adjacency fill beyond store");
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != kcd_pkg::ST_CLEAR |=> st_q != kcd_pkg::ST_CLEAR)
		else $error("clearing pass restarted");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == kcd_pkg::ST_OUT && !out_free |=> st_q == kcd_pkg::ST_OUT)
		else $error("result dropped while output busy");

endmodule
